>>> hdl/cpf_pkg.sv
// Shared types, constants and sine table generator for the Clarke/Park current filter.
package cpf_pkg;

  // Sequencer states: at most one product through the shared multiplier per step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLA,
    ST_CLB,
    ST_TAB,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_F1,
    ST_F2,
    ST_F3
  } state_t;

  // Register map (word index)
  localparam logic REG_ALPHA = 1'b0;
  localparam logic [15:0] ALPHA_RESET = 16'hFFFF;

  // Clarke gains, Q2.30
  localparam int MB_W = 31;
  localparam logic signed [MB_W-1:0] K_SQRT_2_3  = 31'sd876706528;
  localparam logic signed [MB_W-1:0] K_INV_SQRT2 = 31'sd759250125;

  // pi/2 in Q28 for the table series
  localparam logic [31:0] HALF_PI_Q28 = 32'd421657428;

  // Filter state and output format
  localparam int FILT_FRAC = 8;
  localparam int STATE_W   = 32;
  localparam int OUT_W     = 18;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;
  localparam int OUT_TDATA_W = 40;

  // Quarter-wave sine entry in Q15, Q28 Taylor series to x^15, rounded half up
  function automatic logic [15:0] sine_entry(input logic [31:0] idx, input int tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x    = (64'(HALF_PI_Q28) * 64'(idx)) >> tbits;
    x2   = (x * x) >> 28;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 28) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 28) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 28) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 28) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 28) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 28) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 28) / 64'd210;
    sum  = sum - signed'(term);
    sum  = (sum + 64'sd4096) >>> 13;
    return sum[15:0];
  endfunction

endpackage

>>> hdl/cpf_sine_rom.sv
// Quarter-wave sine ROM, Q15 entries, registered read.
module cpf_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic [TABLE_BITS:0]   addr,
  output logic [15:0]           rd_data
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  typedef logic [15:0] rom_t [DEPTH];

  // Table contents worked out at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < DEPTH; i++) begin
      r[i] = cpf_pkg::sine_entry(32'(i), TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Synchronous read
  always_ff @(posedge clk) begin
    rd_data <= SINE_ROM[addr];
  end

endmodule

>>> hdl/clarke_park_current_filter_top.sv
// Clarke/Park current transform with d/q low-pass filters on one shared multiplier.
// The sequencer steps CLA, CLB, TAB, P1 to P4 and F1 to F3, then loads the output register;
// a new input is taken only in idle. Eight products go through the single shared multiplier
// in turn; the two Clarke products overlap the sine ROM reads for sine and cosine.
// A finished result waiting in the output register stalls the sequencer only at its last step.
// Reset (rst, synchronous): filter states cleared, filter_alpha = 65535, output empty.
module clarke_park_current_filter_top #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // current_a, current_b, current_c (SAMPLE_WIDTH each), rotor_angle (16), zero pad
  input  logic [((3*SAMPLE_WIDTH+16+7)/8)*8-1:0] s_tdata,
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // current_d (18), current_q (18), zero pad
  output logic [cpf_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int AL_W  = SW + 1;                  // alpha/beta currents
  localparam int DW    = SW + 2;                  // 2a-b-c, d and q
  localparam int DX_W  = DW + cpf_pkg::FILT_FRAC; // scaled d/q
  localparam int DFW   = ((DX_W > cpf_pkg::STATE_W) ? DX_W : cpf_pkg::STATE_W) + 1;
  localparam int MA_W  = DFW;
  localparam int PW    = MA_W + cpf_pkg::MB_W;
  localparam int AW    = PW + 1;
  localparam int YW    = ((DFW + 1 > cpf_pkg::STATE_W) ? DFW + 1 : cpf_pkg::STATE_W) + 1;
  localparam int PAD_W = cpf_pkg::OUT_TDATA_W - 2 * cpf_pkg::OUT_W;
  localparam logic [TB:0] QUARTER = {1'b1, {TB{1'b0}}};

  cpf_pkg::state_t state, state_next;

  logic [15:0]                  filter_alpha;
  logic signed [SW-1:0]         samp_a, samp_b, samp_c;
  logic [1:0]                   quad;
  logic [TB-1:0]                pos;
  logic [15:0]                  s0, s1;
  logic signed [AL_W-1:0]       al, be;
  logic signed [DW-1:0]         dv, qv;
  logic signed [PW-1:0]         prod;
  logic signed [AW-1:0]         acc;
  logic signed [cpf_pkg::STATE_W-1:0] filt_d, filt_q;
  logic signed [cpf_pkg::OUT_W-1:0]   out_d;

  logic signed [MA_W-1:0]       mul_a;
  logic signed [cpf_pkg::MB_W-1:0] mul_b;
  logic [TB:0]                  rom_addr;
  logic [15:0]                  rom_q;
  logic signed [DW-1:0]         t0;
  logic signed [AL_W-1:0]       t1;
  logic signed [16:0]           sn, cs, s0e, s1e, alpha_s;
  logic signed [MA_W-1:0]       diff_d, diff_q;
  logic signed [cpf_pkg::STATE_W-1:0] filt_sel;
  logic signed [YW-1:0]         y_new, y_rnd;
  logic signed [cpf_pkg::OUT_W-1:0]   y_sat;
  logic                         cfg_wr, in_acc, out_load;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha <= cpf_pkg::ALPHA_RESET;
    end else if (cfg_wr && paddr[2] == cpf_pkg::REG_ALPHA) begin
      filter_alpha <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cpf_pkg::REG_ALPHA) begin
      prdata = {16'b0, filter_alpha};
    end
  end

  // Handshakes
  assign s_tready = (state == cpf_pkg::ST_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign out_load = (state == cpf_pkg::ST_F3) && (!m_tvalid || m_tready);

  // Sine ROM
  cpf_sine_rom #(
    .TABLE_BITS (TB)
  ) u_rom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  // Operand shaping
  assign t0      = (DW'(samp_a) <<< 1) - DW'(samp_b) - DW'(samp_c);
  assign t1      = AL_W'(samp_b) - AL_W'(samp_c);
  assign s0e     = signed'({1'b0, s0});
  assign s1e     = signed'({1'b0, s1});
  assign alpha_s = signed'({1'b0, filter_alpha});
  assign diff_d  = (MA_W'(dv) <<< cpf_pkg::FILT_FRAC) - MA_W'(filt_d);
  assign diff_q  = (MA_W'(qv) <<< cpf_pkg::FILT_FRAC) - MA_W'(filt_q);

  // Quadrant folding of the quarter-wave table
  always_comb begin
    case (quad)
      2'd0: begin
        sn = s0e;
        cs = s1e;
      end
      2'd1: begin
        sn = s1e;
        cs = -s0e;
      end
      2'd2: begin
        sn = -s0e;
        cs = -s1e;
      end
      default: begin
        sn = -s1e;
        cs = s0e;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and ROM address
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rom_addr   = {1'b0, pos};
    case (state)
      cpf_pkg::ST_IDLE: begin
        if (in_acc) state_next = cpf_pkg::ST_CLA;
      end
      cpf_pkg::ST_CLA: begin
        mul_a      = MA_W'(t0);
        mul_b      = cpf_pkg::K_SQRT_2_3;
        state_next = cpf_pkg::ST_CLB;
      end
      cpf_pkg::ST_CLB: begin
        mul_a      = MA_W'(t1);
        mul_b      = cpf_pkg::K_INV_SQRT2;
        rom_addr   = QUARTER - {1'b0, pos};
        state_next = cpf_pkg::ST_TAB;
      end
      cpf_pkg::ST_TAB: begin
        state_next = cpf_pkg::ST_P1;
      end
      cpf_pkg::ST_P1: begin
        mul_a      = MA_W'(al);
        mul_b      = cpf_pkg::MB_W'(cs);
        state_next = cpf_pkg::ST_P2;
      end
      cpf_pkg::ST_P2: begin
        mul_a      = MA_W'(be);
        mul_b      = cpf_pkg::MB_W'(sn);
        state_next = cpf_pkg::ST_P3;
      end
      cpf_pkg::ST_P3: begin
        mul_a      = MA_W'(be);
        mul_b      = cpf_pkg::MB_W'(cs);
        state_next = cpf_pkg::ST_P4;
      end
      cpf_pkg::ST_P4: begin
        mul_a      = MA_W'(al);
        mul_b      = cpf_pkg::MB_W'(sn);
        state_next = cpf_pkg::ST_F1;
      end
      cpf_pkg::ST_F1: begin
        mul_a      = diff_d;
        mul_b      = cpf_pkg::MB_W'(alpha_s);
        state_next = cpf_pkg::ST_F2;
      end
      cpf_pkg::ST_F2: begin
        mul_a      = diff_q;
        mul_b      = cpf_pkg::MB_W'(alpha_s);
        state_next = cpf_pkg::ST_F3;
      end
      cpf_pkg::ST_F3: begin
        // keep the q filter product steady while the output is stalled
        mul_a      = diff_q;
        mul_b      = cpf_pkg::MB_W'(alpha_s);
        if (out_load) state_next = cpf_pkg::ST_IDLE;
      end
      default: begin
        state_next = cpf_pkg::ST_IDLE;
      end
    endcase
  end

  // Filter update: state plus rounded alpha * diff, then round and saturate
  assign filt_sel = (state == cpf_pkg::ST_F2) ? filt_d : filt_q;
  assign y_new    = YW'(filt_sel) + YW'((prod + PW'(2**15)) >>> 16);
  assign y_rnd    = (y_new + YW'(2**(cpf_pkg::FILT_FRAC-1))) >>> cpf_pkg::FILT_FRAC;

  always_comb begin
    if (y_rnd > YW'(cpf_pkg::OUT_MAX)) begin
      y_sat = cpf_pkg::OUT_W'(cpf_pkg::OUT_MAX);
    end else if (y_rnd < YW'(cpf_pkg::OUT_MIN)) begin
      y_sat = cpf_pkg::OUT_W'(cpf_pkg::OUT_MIN);
    end else begin
      y_sat = y_rnd[cpf_pkg::OUT_W-1:0];
    end
  end

  // Shared multiplier, product registered every cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cpf_pkg::ST_IDLE: begin
        if (in_acc) begin
          samp_a <= s_tdata[SW-1:0];
          samp_b <= s_tdata[2*SW-1:SW];
          samp_c <= s_tdata[3*SW-1:2*SW];
          quad   <= s_tdata[3*SW+15 -: 2];
          pos    <= s_tdata[3*SW+13 -: TB];
        end
      end
      cpf_pkg::ST_CLB: begin
        al <= AL_W'((prod + PW'(2**30)) >>> 31);
        s0 <= rom_q;
      end
      cpf_pkg::ST_TAB: begin
        be <= AL_W'((prod + PW'(2**29)) >>> 30);
        s1 <= rom_q;
      end
      cpf_pkg::ST_P2: begin
        acc <= AW'(prod);
      end
      cpf_pkg::ST_P3: begin
        dv <= DW'((acc + AW'(prod) + AW'(2**14)) >>> 15);
      end
      cpf_pkg::ST_P4: begin
        acc <= AW'(prod);
      end
      cpf_pkg::ST_F1: begin
        qv <= DW'((acc - AW'(prod) + AW'(2**14)) >>> 15);
      end
      cpf_pkg::ST_F2: begin
        out_d <= y_sat;
      end
      default: begin
      end
    endcase
  end

  // Filter states
  always_ff @(posedge clk) begin
    if (rst) begin
      filt_d <= '0;
      filt_q <= '0;
    end else if (state == cpf_pkg::ST_F2) begin
      filt_d <= y_new[cpf_pkg::STATE_W-1:0];
    end else if (out_load) begin
      filt_q <= y_new[cpf_pkg::STATE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, y_sat, out_d};
    end
  end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the Clarke/Park current filter: random and corner samples.
`timescale 1ns / 100ps

module tb_top;

  // Scoreboard: d/q predictor with its own filter state and a queue of expected results
  class dq_scoreboard;
    localparam int TAB_BITS = 10;
    localparam int QUARTER  = 1 << TAB_BITS;
    localparam longint GAIN_CLARKE = 64'sd876706528;  // sqrt(2/3), Q2.30
    localparam longint GAIN_BETA   = 64'sd759250125;  // 1/sqrt(2), Q2.30

    typedef struct packed {
      logic [17:0] d;
      logic [17:0] q;
    } dq_t;

    int          sine_q15 [QUARTER+1];
    logic [15:0] alpha;
    int          lp_d;
    int          lp_q;
    dq_t         pending_dq[$];
    int unsigned errors;
    int unsigned inputs_seen;
    int unsigned results_seen;

    // Quarter-wave table from a Q28 Taylor series, then post-reset filter state
    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      for (int i = 0; i <= QUARTER; i++) begin
        x    = (64'd421657428 * 64'(i)) >> TAB_BITS;
        x2   = (x * x) >> 28;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 28) / 64'(4 * k * k + 2 * k);
          if (k % 2 == 1) begin
            sum -= longint'(term);
          end else begin
            sum += longint'(term);
          end
        end
        sine_q15[i] = int'(round_half_up(sum, 13));
      end
      alpha = 16'hFFFF;
      lp_d  = 0;
      lp_q  = 0;
    endfunction

    // floor((v + 2^(n-1)) / 2^n)
    static function longint round_half_up(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // y += alpha*(x - y), state keeps 8 extra fraction bits; output rounded and saturated
    function longint lowpass_step(inout int st, input longint x);
      longint y;
      longint diff;
      y    = st;
      diff = x * 256 - y;
      y   += round_half_up(longint'(alpha) * diff, 16);
      st   = int'(y);
      y    = round_half_up(y, 8);
      if (y > 131071) y = 131071;
      if (y < -131072) y = -131072;
      return y;
    endfunction

    function void set_alpha(logic [15:0] value);
      alpha = value;
    endfunction

    // Accepted input transaction: work out the filtered d/q pair
    function void note_input(logic [63:0] word);
      longint a, b, c, al, be, sn, cs, d, q;
      int     pos;
      dq_t    res;
      a   = longint'($signed(word[15:0]));
      b   = longint'($signed(word[31:16]));
      c   = longint'($signed(word[47:32]));
      al  = round_half_up((2 * a - b - c) * GAIN_CLARKE, 31);
      be  = round_half_up((b - c) * GAIN_BETA, 30);
      // top two angle bits pick the quadrant, next ten the table entry
      pos = int'(word[61:52]);
      case (word[63:62])
        2'd0: begin
          sn = sine_q15[pos];
          cs = sine_q15[QUARTER - pos];
        end
        2'd1: begin
          sn = sine_q15[QUARTER - pos];
          cs = -sine_q15[pos];
        end
        2'd2: begin
          sn = -sine_q15[pos];
          cs = -sine_q15[QUARTER - pos];
        end
        default: begin
          sn = -sine_q15[QUARTER - pos];
          cs = sine_q15[pos];
        end
      endcase
      d     = round_half_up(al * cs + be * sn, 15);
      q     = round_half_up(be * cs - al * sn, 15);
      res.d = 18'(lowpass_step(lp_d, d));
      res.q = 18'(lowpass_step(lp_q, q));
      pending_dq.push_back(res);
      inputs_seen++;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Accepted output transaction against the oldest expectation
    task check_result(logic [39:0] word);
      dq_t want;
      results_seen++;
      if (pending_dq.size() == 0) begin
        report($sformatf("result with none expected: d=%0d q=%0d",
                         $signed(word[17:0]), $signed(word[35:18])));
        return;
      end
      want = pending_dq.pop_front();
      if (word[17:0] !== want.d) begin
        report($sformatf("result %0d current_d: expected %0d, got %0d", results_seen,
                         $signed(want.d), $signed(word[17:0])));
      end
      if (word[35:18] !== want.q) begin
        report($sformatf("result %0d current_q: expected %0d, got %0d", results_seen,
                         $signed(want.q), $signed(word[35:18])));
      end
    endtask
  endclass

  localparam logic [2:0] ADDR_ALPHA = 3'(4 * int'(cpf_pkg::REG_ALPHA));
  localparam logic [2:0] ADDR_SPARE = ADDR_ALPHA + 3'd4;  // no register here
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 325;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // current_a [15:0], current_b [31:16], current_c [47:32], rotor_angle [63:48]
  logic [63:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // current_d [17:0], current_q [35:18], zero pad [39:36]
  logic [cpf_pkg::OUT_TDATA_W-1:0] m_tdata;

  int          tx_idle_pct = 15;
  int          rx_idle_pct = 67;
  int          settings_used;
  logic [15:0] angle_acc = '0;
  logic [15:0] angle_step = 16'd37;

  dq_scoreboard board = new();

  clarke_park_current_filter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Output side: random back-pressure and result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(m_tdata);
    end
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic [63:0] pack_word(int a, int b, int c, int ang);
    return {16'(ang), 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic logic [15:0] corner_current();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Half realistic samples (balanced phases, some with a rotating angle), the rest raw noise and corners
  function automatic logic [63:0] random_word();
    int   sel;
    int   a, b;
    logic [15:0] ang;
    sel = $urandom_range(0, 99);
    ang = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      ang = {2'($urandom_range(0, 3)), 14'h0} | 16'($urandom_range(0, 1) * 16'h3FFF);
    end
    if (sel < 35) begin
      return {ang, 48'({$urandom, $urandom})};
    end else if (sel < 65) begin
      a = $urandom_range(0, 32766) - 16383;
      b = $urandom_range(0, 32766) - 16383;
      return pack_word(a, b, -(a + b), ang);
    end else if (sel < 80) begin
      return {ang, corner_current(), corner_current(), corner_current()};
    end else begin
      if ($urandom_range(0, 19) == 0) angle_step = 16'($urandom_range(1, 900));
      angle_acc += angle_step;
      a = $urandom_range(0, 40000) - 20000;
      b = $urandom_range(0, 40000) - 20000;
      return pack_word(a, b, -(a + b) + $urandom_range(0, 64) - 32, angle_acc);
    end
  endfunction

  // One input transaction, with an optional idle gap before it
  task automatic send_word(input logic [63:0] word);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    board.note_input(word);
  endtask

  // APB write: setup cycle then access cycle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ALPHA) begin
      board.set_alpha(data[15:0]);
      settings_used++;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending_dq.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    int          dir_vals [15][4];
    logic [15:0] new_alpha;
    dir_vals = '{
      '{0, 0, 0, 0},             '{32767, 32767, 32767, 0},
      '{-32768, -32768, -32768, 0}, '{32767, -32768, -32768, 0},
      '{-32768, 32767, 32767, 16384}, '{0, 32767, -32768, 16384},
      '{0, -32768, 32767, 32768}, '{16384, -8192, -8192, 49152},
      '{16384, -8192, -8192, 65535}, '{20000, -10000, -10000, 15},
      '{20000, -10000, -10000, 16}, '{32767, 32767, -32768, 16'h3FF0},
      '{1, -1, 0, 16'hC000},      '{-1, -1, -1, 16'h8000},
      '{32767, 0, -32767, 16'h2000}
    };
    settings_used = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale currents and quadrant boundary angles at reset alpha
    foreach (dir_vals[i]) begin
      send_word(pack_word(dir_vals[i][0], dir_vals[i][1], dir_vals[i][2], dir_vals[i][3]));
    end
    wait_drained();
    // write to an unmapped address must leave alpha alone
    apb_write(ADDR_SPARE, 32'h0000_1234);
    send_word(pack_word(12000, -3000, -9000, 5000));
    wait_drained();
    // alpha of zero: outputs hold the previous state
    apb_write(ADDR_ALPHA, 32'h0);
    send_word(pack_word(32767, -32768, 0, 16'h1234));
    send_word(pack_word(-32768, 32767, 1, 16'hFEDC));
    wait_drained();

    // Random phases over several filter settings and idle patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       new_alpha = 16'hFFFF;
        1:       new_alpha = 16'h0001;
        2:       new_alpha = 16'h8000;
        4:       new_alpha = 16'h0000;
        default: new_alpha = 16'($urandom);
      endcase
      if (ph < 2) begin
        tx_idle_pct = 15;
        rx_idle_pct = 67;
      end else if (ph < 4) begin
        tx_idle_pct = 67;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apb_write(ADDR_ALPHA, {16'($urandom), new_alpha});
      repeat (PHASE_ITEMS) send_word(random_word());
      wait_drained();
    end

    if (board.pending_dq.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.pending_dq.size()));
    end
    $display("Run covered %0d input transactions and %0d results under %0d filter settings,",
             board.inputs_seen, board.results_seen, settings_used);
    $display("with idle and back-pressure on either side and none at all.");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: block stopped responding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
